### rtl/sevseg_pkg.sv
// ----------------------------------------------------------------------------
// sevseg_pkg - shared types and constants of the seven-segment driver
// Command codes, font table, frame layout and the structs that pass
// between the command front end, the frame queue and the serializer.
// ----------------------------------------------------------------------------
package sevseg_pkg;

    // Serial frame: right digit in the upper byte, left digit in the lower.
    localparam int FRAME_BITS  = 16;
    localparam int POS_W       = 4;
    localparam int SEG_W       = 8;
    localparam int QUEUE_DEPTH = 2;

    // Stream payload widths.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    localparam logic [SEG_W-1:0]      SEG_BLANK   = 8'hFF;
    localparam logic [FRAME_BITS-1:0] FRAME_BLANK = 16'hFFFF;
    localparam logic [7:0]            CHAR_FIRST  = 8'h20;
    localparam logic [7:0]            CHAR_LAST   = 8'h7E;
    localparam logic [6:0]            FONT_LAST   = 7'd94;
    localparam logic [6:0]            FONT_DIGIT0 = 7'd16;

    typedef enum logic [2:0] {
        OP_SET_VALUE = 3'd0,
        OP_SET_CHARS = 3'd1,
        OP_DP_ON     = 3'd2,
        OP_DP_OFF    = 3'd3,
        OP_DISP_ON   = 3'd4,
        OP_DISP_OFF  = 3'd5
    } op_t;

    // Frame handed from the front end to the queue.
    typedef struct packed {
        logic                  push;
        logic [FRAME_BITS-1:0] frame;
    } frame_wr_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Active-low segment patterns, ASCII 0x20..0x7E, dp in bit 0.
    localparam logic [SEG_W-1:0] FONT_ROM [0:94] = '{
        8'hFF, 8'hFD, 8'hBB, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFB, 8'h63, 8'h0F,
        8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'h03, 8'h9F, 8'h25, 8'h0D,
        8'h99, 8'h49, 8'h41, 8'h1F, 8'h01, 8'h09, 8'hFD, 8'hFD, 8'hFD, 8'hED,
        8'hFD, 8'h2F, 8'hFD, 8'h11, 8'hC1, 8'h63, 8'h85, 8'h61, 8'h71, 8'h43,
        8'h91, 8'h0F, 8'h07, 8'hA1, 8'hE3, 8'h55, 8'h13, 8'h03, 8'h31, 8'h19,
        8'hF5, 8'h49, 8'hE1, 8'h83, 8'hC7, 8'h47, 8'hD9, 8'h89, 8'hA5, 8'h63,
        8'hFD, 8'h0F, 8'hFD, 8'hEF, 8'hBF, 8'h11, 8'hC1, 8'hE5, 8'h85, 8'h21,
        8'h71, 8'h09, 8'hD1, 8'hF7, 8'h87, 8'h51, 8'hF3, 8'h55, 8'hD5, 8'hC5,
        8'h31, 8'h19, 8'hF5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    function automatic logic [SEG_W-1:0] font_lookup(input logic [6:0] idx);
        logic [SEG_W-1:0] seg;
        if (idx > FONT_LAST) begin
            seg = '0;
        end else begin
            seg = FONT_ROM[idx];
        end
        return seg;
    endfunction

    function automatic logic [SEG_W-1:0] char_glyph(input logic [7:0] code);
        logic [SEG_W-1:0] seg;
        if (code < CHAR_FIRST || code > CHAR_LAST) begin
            seg = SEG_BLANK;
        end else begin
            seg = font_lookup(7'(code - CHAR_FIRST));
        end
        return seg;
    endfunction

endpackage

### rtl/sevseg_front.sv
// ----------------------------------------------------------------------------
// sevseg_front - command decode and digit store
// Accept commands, update the stored segment bytes and queue one frame
// per accepted command; op codes 6 and 7 queue none.
// ----------------------------------------------------------------------------
module sevseg_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sevseg_pkg::S_TDATA_W-1:0]  s_tdata,
    input  sevseg_pkg::queue_status_t         q_status,
    output sevseg_pkg::frame_wr_t             q_wr
);

    logic [sevseg_pkg::SEG_W-1:0] right_reg, right_next;
    logic [sevseg_pkg::SEG_W-1:0] left_reg,  left_next;

    logic [2:0]  op_bits;
    logic [7:0]  value;
    logic [7:0]  char_left;
    logic [7:0]  char_right;
    logic        digit_index;
    logic        accept;
    logic        push;
    logic [6:0]  v_sat;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    logic [sevseg_pkg::FRAME_BITS-1:0] frame;

    assign op_bits     = s_tdata[2:0];
    assign value       = s_tdata[10:3];
    assign char_left   = s_tdata[18:11];
    assign char_right  = s_tdata[26:19];
    assign digit_index = s_tdata[27];

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    // Saturate to 99, then split: tens = v*205 >> 11 holds for v below 1029.
    assign v_sat     = (value > 8'd99) ? 7'd99 : value[6:0];
    assign tens_prod = 15'(v_sat) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign units     = v_sat - 7'(tens) * 7'd10;

    always_comb begin
        right_next = right_reg;
        left_next  = left_reg;
        push       = 1'b1;
        frame      = {right_next, left_next};
        unique case (op_bits)
            sevseg_pkg::OP_SET_VALUE: begin
                if (tens == 4'd0) begin
                    left_next = sevseg_pkg::SEG_BLANK;
                end else begin
                    left_next = sevseg_pkg::font_lookup(7'(tens) + sevseg_pkg::FONT_DIGIT0)
                                | {7'd0, left_reg[0]};
                end
                right_next = sevseg_pkg::font_lookup(units + sevseg_pkg::FONT_DIGIT0)
                             | {7'd0, right_reg[0]};
            end
            sevseg_pkg::OP_SET_CHARS: begin
                left_next  = sevseg_pkg::char_glyph(char_left)  | {7'd0, left_reg[0]};
                right_next = sevseg_pkg::char_glyph(char_right) | {7'd0, right_reg[0]};
            end
            sevseg_pkg::OP_DP_ON: begin
                if (digit_index) begin
                    left_next[0] = 1'b0;
                end else begin
                    right_next[0] = 1'b0;
                end
            end
            sevseg_pkg::OP_DP_OFF: begin
                if (digit_index) begin
                    left_next[0] = 1'b1;
                end else begin
                    right_next[0] = 1'b1;
                end
            end
            sevseg_pkg::OP_DISP_ON: begin
            end
            sevseg_pkg::OP_DISP_OFF: begin
            end
            default: begin
                push = 1'b0;
            end
        endcase
        if (op_bits == sevseg_pkg::OP_DISP_OFF) begin
            frame = sevseg_pkg::FRAME_BLANK;
        end else begin
            frame = {right_next, left_next};
        end
    end

    assign q_wr.push  = accept && push;
    assign q_wr.frame = frame;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_reg <= sevseg_pkg::SEG_BLANK;
            left_reg  <= sevseg_pkg::SEG_BLANK;
        end else if (accept) begin
            right_reg <= right_next;
            left_reg  <= left_next;
        end
    end

endmodule

### rtl/sevseg_queue.sv
// ----------------------------------------------------------------------------
// sevseg_queue - frame queue
// Small first-in first-out buffer of frames between the front end and
// the serializer.
// ----------------------------------------------------------------------------
module sevseg_queue #(
    parameter int DEPTH = sevseg_pkg::QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sevseg_pkg::frame_wr_t               wr,
    input  logic                                pop,
    output logic [sevseg_pkg::FRAME_BITS-1:0]   rd_frame,
    output sevseg_pkg::queue_status_t           status
);

    localparam int AW = $clog2(DEPTH);

    logic [sevseg_pkg::FRAME_BITS-1:0] mem_reg [DEPTH];
    logic [AW:0] wr_ptr_reg, rd_ptr_reg;

    assign status.empty = (wr_ptr_reg == rd_ptr_reg);
    assign status.full  = (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0])
                          && (wr_ptr_reg[AW] != rd_ptr_reg[AW]);
    assign rd_frame     = mem_reg[rd_ptr_reg[AW-1:0]];

    always_ff @(posedge aclk) begin
        if (wr.push) begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= wr.frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (wr.push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

### rtl/sevseg_serializer.sv
// ----------------------------------------------------------------------------
// sevseg_serializer - frame shifter
// Take frames from the queue and send them one bit per transfer,
// least significant bit first, marking the last bit.
// ----------------------------------------------------------------------------
module sevseg_serializer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [sevseg_pkg::FRAME_BITS-1:0] q_frame,
    input  sevseg_pkg::queue_status_t         q_status,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sevseg_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast
);

    localparam logic [sevseg_pkg::POS_W-1:0] LAST_POS =
        sevseg_pkg::POS_W'(sevseg_pkg::FRAME_BITS - 1);

    logic [sevseg_pkg::FRAME_BITS-1:0] shift_reg;
    logic [sevseg_pkg::POS_W-1:0]      pos_reg;
    logic                              active_reg;
    logic                              last;
    logic                              done;

    assign last  = (pos_reg == LAST_POS);
    assign done  = m_tready && last;
    assign q_pop = !q_status.empty && (!active_reg || done);

    assign m_tvalid = active_reg;
    assign m_tlast  = last;
    assign m_tdata  = {3'd0, pos_reg, shift_reg[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
        end else if (q_pop) begin
            active_reg <= 1'b1;
            pos_reg    <= '0;
        end else if (active_reg && m_tready) begin
            if (last) begin
                active_reg <= 1'b0;
            end
            pos_reg <= pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            shift_reg <= q_frame;
        end else if (active_reg && m_tready) begin
            shift_reg <= {1'b0, shift_reg[sevseg_pkg::FRAME_BITS-1:1]};
        end
    end

endmodule

### rtl/two_digit_seven_segment_driver_core.sv
// ----------------------------------------------------------------------------
// two_digit_seven_segment_driver_core - two-digit seven-segment driver
// Command stream in, serial shift-register bit stream out.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel (s_*) takes one command per transfer: set a value,
//   set two characters, turn a decimal point on or off, resend the stored
//   digits or blank the display. Op codes 6 and 7 are dropped with no output.
//   The master channel (m_*) sends the resulting 16-bit frame as 16
//   transfers, one per bit, least significant bit first; the frame holds the
//   left digit in bits 7:0 and the right digit in bits 15:8. m_tlast marks
//   the last bit, after which the storage latch is pulsed.
//   Flow: a command's frame is written into the frame queue and then loaded
//   into the serializer's shift register, which shows its first bit. Bits
//   leave at one bit per cycle while m_tready is high, and the next frame is
//   loaded as the last bit leaves; the front end takes the next command as long
//   as the frame queue (QUEUE_DEPTH frames) has room.
//   Reset: both stored digits go to all segments off (0xFF), the queue
//   empties and no bit is in flight.
//   Stall: while m_tready is low, the current bit holds; frames build up in
//   the queue and s_tready drops once the queue is full.
// ----------------------------------------------------------------------------
module two_digit_seven_segment_driver_core #(
    parameter int QUEUE_DEPTH = sevseg_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // op[2:0], value[10:3], char_left[18:11], char_right[26:19],
    // digit_index[27], zero[31:28]
    input  logic [sevseg_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // serial_bit[0], bit_position[4:1], zero[7:5]
    output logic [sevseg_pkg::M_TDATA_W-1:0]  m_tdata,
    // latch_after
    output logic                              m_tlast
);

    sevseg_pkg::frame_wr_t              q_wr;
    sevseg_pkg::queue_status_t          q_status;
    logic [sevseg_pkg::FRAME_BITS-1:0]  q_frame;
    logic                               q_pop;

    // Decode commands and keep the digit bytes.
    sevseg_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .q_wr     (q_wr)
    );

    // Buffer frames so the command side does not wait on the shifter.
    sevseg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (q_wr),
        .pop      (q_pop),
        .rd_frame (q_frame),
        .status   (q_status)
    );

    // Shift frames out one bit per transfer.
    sevseg_serializer u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_frame  (q_frame),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### sim/tb_two_digit_seven_segment_driver_core.sv
// ----------------------------------------------------------------------------
// tb_two_digit_seven_segment_driver_core - self-checking bench for the driver
// Sends display commands over the slave stream and checks every serial frame
// bit on the master stream against a cycle-free model of the two segment
// bytes. A short table of hand-picked commands runs first, then a couple of
// hundred random commands under bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_two_digit_seven_segment_driver_core;

    localparam int          CLK_HALF      = 5;
    localparam int          RESET_CYCLES  = 9;
    localparam int          RANDOM_CMDS   = 220;
    localparam int          HOLD_AT       = 80;    // random command that starts the long hold
    localparam int          PAUSE_AT      = 160;   // random command after which input pauses
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_CYCLES  = 40;
    localparam int          IDLE_LIMIT    = 2000;
    localparam int          REPORT_LIMIT  = 40;
    localparam int          VALUE_MAX     = 99;
    localparam logic [2:0]  OP_RSVD6      = 3'd6;
    localparam logic [2:0]  OP_RSVD7      = 3'd7;
    localparam logic        DIGIT_RIGHT   = 1'b0;
    localparam logic        DIGIT_LEFT    = 1'b1;

    // Active-low glyphs for ASCII 0x20..0x7E, decimal point in bit 0.
    localparam logic [7:0] GLYPHS [0:94] = '{
        8'hFF, 8'hFD, 8'hBB, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFB, 8'h63, 8'h0F,
        8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'h03, 8'h9F, 8'h25, 8'h0D,
        8'h99, 8'h49, 8'h41, 8'h1F, 8'h01, 8'h09, 8'hFD, 8'hFD, 8'hFD, 8'hED,
        8'hFD, 8'h2F, 8'hFD, 8'h11, 8'hC1, 8'h63, 8'h85, 8'h61, 8'h71, 8'h43,
        8'h91, 8'h0F, 8'h07, 8'hA1, 8'hE3, 8'h55, 8'h13, 8'h03, 8'h31, 8'h19,
        8'hF5, 8'h49, 8'hE1, 8'h83, 8'hC7, 8'h47, 8'hD9, 8'h89, 8'hA5, 8'h63,
        8'hFD, 8'h0F, 8'hFD, 8'hEF, 8'hBF, 8'h11, 8'hC1, 8'hE5, 8'h85, 8'h21,
        8'h71, 8'h09, 8'hD1, 8'hF7, 8'h87, 8'h51, 8'hF3, 8'h55, 8'hD5, 8'hC5,
        8'h31, 8'h19, 8'hF5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] value;
        logic [7:0] char_left;
        logic [7:0] char_right;
        logic       digit_index;
    } cmd_t;

    // One row of the directed table; frame is typed in only where known is set.
    typedef struct packed {
        cmd_t        cmd;
        logic        known;
        logic [15:0] frame;
    } cmd_row_t;

    // One serial bit as it should leave the block.
    typedef struct packed {
        logic       serial_bit;
        logic [3:0] bit_position;
        logic       latch_after;
    } frame_bit_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

    localparam int DIRECTED_ROWS = 25;

    // Walk extremes, every op, saturation, blank tens, dp carry-over,
    // out-of-range characters, the zero font rows and the unused op codes.
    cmd_row_t directed_cmds [0:DIRECTED_ROWS-1] = '{
        '{'{sevseg_pkg::OP_DISP_ON,   8'd0,   8'h00, 8'h00, DIGIT_RIGHT}, 1'b1, 16'hFFFF},
        '{'{sevseg_pkg::OP_DISP_OFF,  8'd0,   8'h00, 8'h00, DIGIT_RIGHT}, 1'b1, 16'hFFFF},
        '{'{sevseg_pkg::OP_SET_VALUE, 8'd0,   8'h00, 8'h00, DIGIT_RIGHT}, 1'b1, 16'h03FF},
        '{'{sevseg_pkg::OP_SET_VALUE, 8'd255, 8'h00, 8'h00, DIGIT_RIGHT}, 1'b1, 16'h0909},
        '{'{sevseg_pkg::OP_DP_ON,     8'd0,   8'h00, 8'h00, DIGIT_RIGHT}, 1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_DP_ON,     8'd0,   8'h00, 8'h00, DIGIT_LEFT},  1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_SET_VALUE, 8'd5,   8'h00, 8'h00, DIGIT_RIGHT}, 1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_DP_ON,     8'd0,   8'h00, 8'h00, DIGIT_RIGHT}, 1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_DP_OFF,    8'd0,   8'h00, 8'h00, DIGIT_RIGHT}, 1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_DP_OFF,    8'd0,   8'h00, 8'h00, DIGIT_LEFT},  1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_SET_CHARS, 8'd0,   8'h00, 8'hFF, DIGIT_RIGHT}, 1'b1, 16'hFFFF},
        '{'{sevseg_pkg::OP_SET_CHARS, 8'd0,   8'h1F, 8'h7F, DIGIT_RIGHT}, 1'b1, 16'hFFFF},
        '{'{sevseg_pkg::OP_SET_CHARS, 8'd0,   8'h20, 8'h7E, DIGIT_RIGHT}, 1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_DP_ON,     8'd0,   8'h00, 8'h00, DIGIT_RIGHT}, 1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_SET_CHARS, 8'd0,   8'h73, 8'h41, DIGIT_RIGHT}, 1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_SET_CHARS, 8'd0,   8'h48, 8'h69, DIGIT_LEFT},  1'b0, 16'h0000},
        '{'{OP_RSVD6,                 8'd77,  8'h41, 8'h42, DIGIT_LEFT},  1'b0, 16'h0000},
        '{'{OP_RSVD7,                 8'd12,  8'h43, 8'h44, DIGIT_RIGHT}, 1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_DISP_OFF,  8'd0,   8'h00, 8'h00, DIGIT_RIGHT}, 1'b1, 16'hFFFF},
        '{'{sevseg_pkg::OP_DISP_ON,   8'd0,   8'h00, 8'h00, DIGIT_RIGHT}, 1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_SET_VALUE, 8'd100, 8'h00, 8'h00, DIGIT_RIGHT}, 1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_SET_VALUE, 8'd10,  8'h00, 8'h00, DIGIT_RIGHT}, 1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_SET_VALUE, 8'd9,   8'h00, 8'h00, DIGIT_RIGHT}, 1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_DP_ON,     8'd0,   8'h00, 8'h00, DIGIT_LEFT},  1'b0, 16'h0000},
        '{'{sevseg_pkg::OP_SET_VALUE, 8'd42,  8'h00, 8'h00, DIGIT_RIGHT}, 1'b0, 16'h0000}
    };

    // DUT-facing signals; the ones the bench drives are known from time zero.
    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [sevseg_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [sevseg_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                              m_tlast;

    // Model of the two stored segment bytes.
    logic [7:0]  right_seg;
    logic [7:0]  left_seg;

    frame_bit_t  pending_bits[$];
    int          mismatch_count = 0;
    int          bits_checked   = 0;
    int          ignored_cmds   = 0;
    int          op_counts [0:5] = '{default: 0};
    int          hold_req       = 0;
    int          hold_served    = 0;

    two_digit_seven_segment_driver_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [7:0] glyph_for(input logic [7:0] code);
        if (code < sevseg_pkg::CHAR_FIRST || code > sevseg_pkg::CHAR_LAST) begin
            return 8'hFF;
        end
        return GLYPHS[code - sevseg_pkg::CHAR_FIRST];
    endfunction

    // Update the stored bytes for one command and return the frame it sends.
    task automatic next_frame(input cmd_t c, output logic sends, output logic [15:0] frame);
        logic [7:0] v;
        logic [7:0] tens;
        logic [7:0] units;
        sends = 1'b1;
        case (c.op)
            sevseg_pkg::OP_SET_VALUE: begin
                v     = (c.value > VALUE_MAX) ? 8'(VALUE_MAX) : c.value;
                tens  = v / 10;
                units = v % 10;
                // A zero tens digit blanks the whole left digit, dp included.
                if (tens == 0) begin
                    left_seg = 8'hFF;
                end else begin
                    left_seg = GLYPHS[tens + 16] | {7'b0, left_seg[0]};
                end
                right_seg = GLYPHS[units + 16] | {7'b0, right_seg[0]};
            end
            sevseg_pkg::OP_SET_CHARS: begin
                left_seg  = glyph_for(c.char_left)  | {7'b0, left_seg[0]};
                right_seg = glyph_for(c.char_right) | {7'b0, right_seg[0]};
            end
            sevseg_pkg::OP_DP_ON: begin
                if (c.digit_index == DIGIT_RIGHT) begin
                    right_seg[0] = 1'b0;
                end else begin
                    left_seg[0] = 1'b0;
                end
            end
            sevseg_pkg::OP_DP_OFF: begin
                if (c.digit_index == DIGIT_RIGHT) begin
                    right_seg[0] = 1'b1;
                end else begin
                    left_seg[0] = 1'b1;
                end
            end
            sevseg_pkg::OP_DISP_ON: begin
            end
            sevseg_pkg::OP_DISP_OFF: begin
            end
            default: begin
                sends = 1'b0;
            end
        endcase
        frame = (c.op == sevseg_pkg::OP_DISP_OFF) ? sevseg_pkg::FRAME_BLANK
                                                  : {right_seg, left_seg};
    endtask

    // Queue the sixteen serial bits of one frame, LSB first.
    task automatic queue_frame(input logic [15:0] frame);
        frame_bit_t fb;
        for (int i = 0; i < sevseg_pkg::FRAME_BITS; i++) begin
            fb.serial_bit   = frame[i];
            fb.bit_position = 4'(i);
            fb.latch_after  = (i == sevseg_pkg::FRAME_BITS - 1);
            pending_bits.push_back(fb);
        end
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] bit check failed: %s want %0h got %0h", $realtime, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one command and hold it until the transfer happens; then run the
    // model on it. Valid stays high afterward, the caller drops it for a gap.
    task automatic send_cmd(input cmd_t c, output logic sends, output logic [15:0] frame);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, c.digit_index, c.char_right, c.char_left, c.value, c.op};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        next_frame(c, sends, frame);
        if (sends) begin
            op_counts[c.op]++;
        end else begin
            ignored_cmds++;
        end
    endtask

    // Mostly printable characters, with the full byte range mixed in.
    function automatic logic [7:0] random_char();
        logic [7:0] ch;
        if ($urandom_range(0, 3) == 0) begin
            ch = 8'($urandom);
        end else begin
            ch = 8'($urandom_range(sevseg_pkg::CHAR_FIRST, sevseg_pkg::CHAR_LAST));
        end
        return ch;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            c.op = (pick < 2) ? OP_RSVD6 : OP_RSVD7;
        end else begin
            c.op = 3'($urandom_range(sevseg_pkg::OP_SET_VALUE, sevseg_pkg::OP_DISP_OFF));
        end
        case ($urandom_range(0, 2))
            0:       c.value = 8'($urandom_range(0, VALUE_MAX));
            1:       c.value = 8'($urandom_range(VALUE_MAX + 1, 255));
            default: c.value = 8'($urandom);
        endcase
        c.char_left   = random_char();
        c.char_right  = random_char();
        c.digit_index = 1'($urandom);
        return c;
    endfunction

    // Drop valid for a random gap; sometimes none, now and then a long one.
    task automatic idle_gap();
        int gap;
        case ($urandom_range(0, 9))
            0, 1, 2: gap = 0;
            9:       gap = $urandom_range(15, 30);
            default: gap = $urandom_range(1, 6);
        endcase
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern that changes mode every so often, and
    // serve the long hold-off that the sender asks for.
    // ------------------------------------------------------------------
    int       rx_cycle  = 0;
    int       hold_left = 0;
    rx_mode_t rx_mode   = RX_OPEN;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (hold_req != hold_served) begin
                hold_served = hold_req;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (rx_cycle % 97 == 0) begin
                    rx_mode = rx_mode_t'($urandom_range(RX_OPEN, RX_BURSTY));
                end
                case (rx_mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom);
                    RX_SPARSE: m_tready <= (rx_cycle % 4 == 0);
                    default:   m_tready <= (rx_cycle % 16 < 11);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Output checker: compare each bit transfer with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        frame_bit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bits.size() == 0) begin
                report_mismatch("unexpected bit, none pending:", 0, m_tdata);
            end else begin
                want = pending_bits.pop_front();
                bits_checked++;
                if (m_tdata[0] !== want.serial_bit) begin
                    report_mismatch("serial_bit", want.serial_bit, m_tdata[0]);
                end
                if (m_tdata[4:1] !== want.bit_position) begin
                    report_mismatch("bit_position", want.bit_position, m_tdata[4:1]);
                end
                if (m_tlast !== want.latch_after) begin
                    report_mismatch("latch_after", want.latch_after, m_tlast);
                end
                if (m_tdata[7:5] !== 3'b000) begin
                    report_mismatch("pad bits", 0, m_tdata[7:5]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no transfer happens on either side for a
    // long stretch.
    // ------------------------------------------------------------------
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge aclk);
        while (!aresetn) begin
            @(posedge aclk);
        end
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic        sends;
        logic [15:0] frame;
        cmd_t        c;
        int          random_sent;
        int          burst;
        int          total_cmds;

        random_sent = 0;
        right_seg   = 8'hFF;
        left_seg    = 8'hFF;

        // Hold reset, then release it once.
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: use the typed-in frame where there is one.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_cmd(directed_cmds[r].cmd, sends, frame);
            if (sends) begin
                queue_frame(directed_cmds[r].known ? directed_cmds[r].frame : frame);
            end
            idle_gap();
        end

        // Random commands in bursts; reserved ops do not count toward the total.
        while (random_sent < RANDOM_CMDS) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && random_sent < RANDOM_CMDS; k++) begin
                c = random_cmd();
                send_cmd(c, sends, frame);
                if (sends) begin
                    queue_frame(frame);
                    random_sent++;
                    // Let the receiver hold off while commands keep coming,
                    // so the frame queue fills and input backs up.
                    if (random_sent == HOLD_AT) begin
                        hold_req <= hold_req + 1;
                    end
                    // Stop offering until every pending bit has drained.
                    if (random_sent == PAUSE_AT) begin
                        s_tvalid <= 1'b0;
                        while (pending_bits.size() != 0) begin
                            @(posedge aclk);
                        end
                    end
                end
            end
            idle_gap();
        end

        // Drain: wait for the last bits, then a few more cycles for strays.
        s_tvalid <= 1'b0;
        while (pending_bits.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        total_cmds = 0;
        foreach (op_counts[i]) begin
            total_cmds += op_counts[i];
        end
        $display("Covered %0d commands: set-value %0d, set-chars %0d, dp-on %0d, dp-off %0d,",
                 total_cmds, op_counts[sevseg_pkg::OP_SET_VALUE],
                 op_counts[sevseg_pkg::OP_SET_CHARS], op_counts[sevseg_pkg::OP_DP_ON],
                 op_counts[sevseg_pkg::OP_DP_OFF]);
        $display("display-on %0d, display-off %0d, %0d reserved dropped; %0d frame bits checked",
                 op_counts[sevseg_pkg::OP_DISP_ON], op_counts[sevseg_pkg::OP_DISP_OFF],
                 ignored_cmds, bits_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
